>>> design/smt_pkg.sv
// Package for the sorted multiset table: sizes, command and status codes,
// controller states and the per-cell operation struct. No dependencies.
package smt_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int COPIES_W = 5;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int SIZE_W   = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WIDE_W   = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  typedef logic [ELEM_W-1:0] key_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_COUNT  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

  // Signed value onto an unsigned key of the same order.
  function automatic key_t to_key(logic [VALUE_W-1:0] v);
    key_t k;
    k = v[ELEM_W-1:0];
    k[ELEM_W-1] = ~k[ELEM_W-1];
    return k;
  endfunction

endpackage

>>> design/smt_in_if.sv
// Input channel of the sorted multiset table: valid/ready plus command item.
// Depends on smt_pkg.
interface smt_in_if import smt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  value;
  logic [COPIES_W-1:0] copies;

  modport source (output valid, cmd, value, copies, input ready);
  modport sink   (input valid, cmd, value, copies, output ready);
endinterface

>>> design/smt_out_if.sv
// Result channel of the sorted multiset table: valid/ready plus result item.
// Depends on smt_pkg.
interface smt_out_if import smt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [OCC_W-1:0]    occurrences;
  logic [SIZE_W-1:0]   size;
  logic                empty_res;

  modport source (output valid, status, found, occurrences, size, empty_res, input ready);
  modport sink   (input valid, status, found, occurrences, size, empty_res, output ready);
endinterface

>>> design/sorted_multiset_table.sv
// Sorted multiset table: a chain of compare-and-shift cells with a controller.
// An accepted item is registered and executed in S_EXEC; its result is registered
// when it finishes. An insert of N >= 1 copies enters one copy per cycle, the last
// only when the result slot is free, and no new item is taken before the current one
// finishes; a stalled result holds the last step. Depends on smt_pkg, smt_in_if,
// smt_out_if, smt_cell, smt_enc. Reset empties the table at once.
module sorted_multiset_table import smt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  smt_in_if.sink  in_i,
  smt_out_if.source out_o
);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  cmd_e   cmd_q;
  key_t   key_q;
  logic [COPIES_W-1:0] left_q, left_d;
  logic   rej_q;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [OCC_W-1:0]    occ_q;
  logic [SIZE_W-1:0]   size_q;
  logic                empty_q;

  logic accept, out_free, ins_step, rem_step, finish;
  cell_op_t op;

  key_t                entry_v [CAPACITY];
  logic [CAPACITY-1:0] valid_v, le_v, lt_v;
  logic [CAPACITY:0]   seen_v;
  cnt_t                n_le, n_lt;

  // Cell chain
  assign seen_v[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_v[i] = cnt_t'(i) < count_q;
    smt_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .key_i        (key_q),
      .valid_i      (valid_v[i]),
      .left_entry_i ((i == 0) ? key_t'('0) : entry_v[(i == 0) ? 0 : i-1]),
      .left_le_i    ((i == 0) ? 1'b1 : le_v[(i == 0) ? 0 : i-1]),
      .right_entry_i((i == CAPACITY-1) ? key_t'('0)
                                       : entry_v[(i == CAPACITY-1) ? i : i+1]),
      .seen_i       (seen_v[i]),
      .entry_o      (entry_v[i]),
      .le_o         (le_v[i]),
      .lt_o         (lt_v[i]),
      .seen_o       (seen_v[i+1])
    );
  end

  smt_enc u_enc_le (.therm_i(le_v), .num_o(n_le));
  smt_enc u_enc_lt (.therm_i(lt_v), .num_o(n_lt));

  // Controller outputs
  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    in_i.ready = 1'b0;
    ins_step   = 1'b0;
    rem_step   = 1'b0;
    finish     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
      end
      S_EXEC: begin
        ins_step = (cmd_q == CMD_INSERT) && (left_q != '0)
                   && ((left_q != COPIES_W'(1)) || out_free);
        finish   = out_free && ((cmd_q != CMD_INSERT) || (left_q <= COPIES_W'(1)));
        rem_step = finish && (cmd_q == CMD_REMOVE) && seen_v[CAPACITY];
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign op.ins = ins_step;
  assign op.rem = rem_step;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins_step) begin
      count_d = count_q + cnt_t'(1);
    end else if (rem_step) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  always_comb begin
    left_d = left_q;
    if (ins_step) left_d = left_q - COPIES_W'(1);
  end

  // Result item
  logic [WIDE_W-1:0]   occ_full, size_full;
  logic [STATUS_W-1:0] status_d;

  assign occ_full  = WIDE_W'(n_le - n_lt);
  assign size_full = WIDE_W'(count_d);

  always_comb begin
    status_d = ST_OK;
    case (cmd_q)
      CMD_INSERT: if (rej_q) status_d = ST_FULL;
      CMD_REMOVE: if (!seen_v[CAPACITY]) status_d = ST_NOTFOUND;
      default:    status_d = ST_OK;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_i.cmd);
      key_q  <= to_key(in_i.value);
      rej_q  <= (WIDE_W + 1)'(count_q) + (WIDE_W + 1)'(in_i.copies)
                > (WIDE_W + 1)'(CAPACITY);
      left_q <= ((cmd_e'(in_i.cmd) == CMD_INSERT)
                 && ((WIDE_W + 1)'(count_q) + (WIDE_W + 1)'(in_i.copies)
                     <= (WIDE_W + 1)'(CAPACITY))) ? in_i.copies : '0;
    end else begin
      left_q <= left_d;
    end
    if (finish) begin
      status_q <= status_d;
      found_q  <= (cmd_q == CMD_SEARCH) && (occ_full != '0);
      occ_q    <= (cmd_q != CMD_COUNT) ? '0
                : (occ_full > WIDE_W'({OCC_W{1'b1}})) ? {OCC_W{1'b1}}
                : occ_full[OCC_W-1:0];
      size_q   <= size_full[SIZE_W-1:0];
      empty_q  <= (count_d == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.found       = found_q;
  assign out_o.occurrences = occ_q;
  assign out_o.size        = size_q;
  assign out_o.empty_res   = empty_q;

  // Checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((le_v >> 1) & ~le_v) == '0)
    else $error("cell chain out of order");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted item not executed");

  a_rem_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_step |-> count_q != '0)
    else $error("remove from empty table");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished item gave no result");

endmodule

>>> design/smt_cell.sv
// One storage cell of the sorted chain: holds a key, compares it with the
// command key and shifts toward either neighbor. Depends on smt_pkg.
module smt_cell import smt_pkg::*; (
  input  logic     clk_i,
  input  cell_op_t op_i,
  input  key_t     key_i,
  input  logic     valid_i,
  input  key_t     left_entry_i,
  input  logic     left_le_i,
  input  key_t     right_entry_i,
  input  logic     seen_i,
  output key_t     entry_o,
  output logic     le_o,
  output logic     lt_o,
  output logic     seen_o
);

  key_t entry_q, entry_d;

  assign le_o    = valid_i && (entry_q <= key_i);
  assign lt_o    = valid_i && (entry_q <  key_i);
  assign seen_o  = seen_i || (valid_i && (entry_q == key_i));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins && !le_o) begin
      entry_d = left_le_i ? key_i : left_entry_i;
    end else if (op_i.rem && seen_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> design/smt_enc.sv
// Thermometer-to-count encoder: number of leading ones of a prefix vector.
// Depends on smt_pkg.
module smt_enc import smt_pkg::*; (
  input  logic [CAPACITY-1:0] therm_i,
  output cnt_t                num_o
);

  logic [CAPACITY-1:0] edge_v;
  logic [CAPACITY:0]   ext;

  assign ext = {1'b0, therm_i};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      edge_v[i] = ext[i] && !ext[i+1];
    end
  end

  always_comb begin
    cnt_t pos;
    num_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos   = cnt_t'(i + 1);
      num_o = num_o | (pos & {CNT_W{edge_v[i]}});
    end
  end

endmodule
